### src/ssbt_pkg.sv
// Shared constants and types for the sorted segment base table.
// Opcodes, status codes, result field widths and the compare result struct.
// No dependencies.
package ssbt_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int BASE_W          = 64;
	localparam int IDX_W           = 6;
	localparam int CNT_W           = 7;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_RETAIN = 2'd2;
	localparam logic [1:0] OP_LOOKUP = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic le;
		logic eq;
	} cmp_res_t;

endpackage

### src/ssbt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ssbt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### src/ssbt_cmp.sv
// Shared 64-bit magnitude compare unit for the table walk.
// Depends on ssbt_pkg (cmp_res_t, BASE_W).
module ssbt_cmp (
	input  logic [ssbt_pkg::BASE_W-1:0] entry,
	input  logic [ssbt_pkg::BASE_W-1:0] probe,
	output ssbt_pkg::cmp_res_t          res
);
	import ssbt_pkg::*;

	assign res.le = (entry <= probe);
	assign res.eq = (entry == probe);

endmodule

### src/sorted_segment_base_table_top.sv
// Top level of the sorted segment base table: sequencer, output register.
// Depends on ssbt_pkg, ssbt_ram and ssbt_cmp.
//
//   Input channel (in_valid / in_stall, opcode, value) takes one command beat:
//   clear, insert, retain or lookup. Output channel (out_valid / out_stall)
//   returns exactly one result beat per command.
//   The table lives in one RAM with one read and one write port. A single
//   compare unit walks the entries from the top down, one entry per cycle,
//   to find the last entry at or below value; insert then shifts the upper
//   entries up one per cycle and retain copies the kept entries down one
//   per cycle, both driven by the RAM ports.
//   One command is worked on at a time and in_stall stays high until its
//   result is loaded into the output register.
//   A waiting result does not block the next command; a finished result
//   holds in the sequencer while an earlier beat waits under out_stall.
//   Reset empties the table at once (count to zero); RAM contents are not
//   cleared and entries above the count are never read.
module sorted_segment_base_table_top #(
	parameter int MAX_ENTRIES = ssbt_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  opcode,
	input  logic [ssbt_pkg::BASE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [ssbt_pkg::IDX_W-1:0]  found_index,
	output logic [ssbt_pkg::BASE_W-1:0] found_base,
	output logic [ssbt_pkg::IDX_W-1:0]  removed,
	output logic [ssbt_pkg::CNT_W-1:0]  entry_count,
	output logic [ssbt_pkg::BASE_W-1:0] first_base
);
	import ssbt_pkg::*;

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_PLACE,
		S_COPY,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [BASE_W-1:0]   first_q;
	logic [1:0]          op_q;
	logic [BASE_W-1:0]   value_q;

	// walk pointer, read-in-flight tracking and limits
	logic [IW-1:0]       scan_q;
	logic                more_q;
	logic                pend_q;
	logic [IW-1:0]       pidx_q;
	logic [IW-1:0]       lim_q;
	logic [IW-1:0]       drop_q;

	// result under construction
	logic [1:0]          res_status_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic [BASE_W-1:0]   res_base_q;
	logic [IDX_W-1:0]    res_removed_q;

	// output register
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [IDX_W-1:0]    found_index_q;
	logic [BASE_W-1:0]   found_base_q;
	logic [IDX_W-1:0]    removed_q;
	logic [CNT_W-1:0]    entry_count_q;
	logic [BASE_W-1:0]   first_base_q;

	logic                ram_we;
	logic [IW-1:0]       ram_waddr;
	logic [BASE_W-1:0]   ram_wdata;
	logic                ram_re;
	logic [BASE_W-1:0]   ram_rdata;
	cmp_res_t            cmp_res;

	logic                hit;
	logic                miss;
	logic [IW-1:0]       pos_n;
	logic [IW-1:0]       last_idx;

	ssbt_ram #(
		.WIDTH(BASE_W),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(scan_q),
		.rdata(ram_rdata)
	);

	ssbt_cmp u_cmp (
		.entry(ram_rdata),
		.probe(value_q),
		.res  (cmp_res)
	);

	// A hit is the first entry, walking down, at or below the probe.
	// A miss is the walk running off the bottom or an empty table.
	assign hit      = pend_q && cmp_res.le;
	assign miss     = (pend_q && !cmp_res.le && (pidx_q == '0)) || (!pend_q && !more_q);
	assign pos_n    = hit ? (pidx_q + IW'(1)) : '0;
	assign last_idx = IW'(count_q - CW'(1));

	// RAM port steering: read at the walk pointer, write back the entry whose read has returned.
	always_comb begin
		ram_re    = more_q && ((state_q == S_SEARCH) || (state_q == S_SHIFT) ||
			(state_q == S_COPY));
		ram_we    = 1'b0;
		ram_waddr = lim_q;
		ram_wdata = value_q;
		case (state_q)
			S_SHIFT: begin
				ram_we    = pend_q;
				ram_waddr = pidx_q + IW'(1);
				ram_wdata = ram_rdata;
			end
			S_COPY: begin
				ram_we    = pend_q;
				ram_waddr = pidx_q - drop_q;
				ram_wdata = ram_rdata;
			end
			S_PLACE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			first_q       <= '0;
			op_q          <= OP_CLEAR;
			value_q       <= '0;
			scan_q        <= '0;
			more_q        <= 1'b0;
			pend_q        <= 1'b0;
			pidx_q        <= '0;
			lim_q         <= '0;
			drop_q        <= '0;
			res_status_q  <= ST_OK;
			res_idx_q     <= '0;
			res_base_q    <= '0;
			res_removed_q <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_OK;
			found_index_q <= '0;
			found_base_q  <= '0;
			removed_q     <= '0;
			entry_count_q <= '0;
			first_base_q  <= '0;
		end else begin
			// drop the output beat once taken
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q          <= opcode;
						value_q       <= value;
						res_status_q  <= ST_OK;
						res_idx_q     <= '0;
						res_base_q    <= '0;
						res_removed_q <= '0;
						pend_q        <= 1'b0;
						if (opcode == OP_CLEAR) begin
							count_q <= '0;
							state_q <= S_DONE;
						end else if ((opcode == OP_INSERT) &&
							(count_q == CW'(MAX_ENTRIES))) begin
							res_status_q <= ST_FULL;
							state_q      <= S_DONE;
						end else begin
							scan_q  <= last_idx;
							more_q  <= (count_q != '0);
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					pend_q <= more_q;
					pidx_q <= scan_q;
					if (more_q) begin
						scan_q <= scan_q - IW'(1);
						more_q <= (scan_q != '0);
					end
					if (hit || miss) begin
						pend_q <= 1'b0;
						case (op_q)
							OP_LOOKUP: begin
								res_status_q <= hit ? ST_OK : ST_NOT_FOUND;
								res_idx_q    <= hit ? IDX_W'(pidx_q) : '0;
								res_base_q   <= hit ? ram_rdata : '0;
								state_q      <= S_DONE;
							end
							OP_INSERT: begin
								if (hit && cmp_res.eq) begin
									state_q <= S_DONE;
								end else begin
									lim_q <= pos_n;
									if (CW'(pos_n) == count_q) begin
										state_q <= S_PLACE;
									end else begin
										scan_q  <= last_idx;
										more_q  <= 1'b1;
										state_q <= S_SHIFT;
									end
								end
							end
							OP_RETAIN: begin
								if (hit && (pidx_q != '0)) begin
									drop_q        <= pidx_q;
									first_q       <= ram_rdata;
									res_removed_q <= IDX_W'(pidx_q);
									scan_q        <= pidx_q;
									lim_q         <= last_idx;
									more_q        <= 1'b1;
									state_q       <= S_COPY;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SHIFT: begin
					// move entries up one, top first, down to the insert slot
					pend_q <= more_q;
					pidx_q <= scan_q;
					if (more_q) begin
						scan_q <= scan_q - IW'(1);
						more_q <= (scan_q != lim_q);
					end
					if (pend_q && !more_q) begin
						pend_q  <= 1'b0;
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					count_q <= count_q + CW'(1);
					if (lim_q == '0) begin
						first_q <= value_q;
					end
					state_q <= S_DONE;
				end
				S_COPY: begin
					// move kept entries down to the bottom, lowest first
					pend_q <= more_q;
					pidx_q <= scan_q;
					if (more_q) begin
						scan_q <= scan_q + IW'(1);
						more_q <= (scan_q != lim_q);
					end
					if (pend_q && !more_q) begin
						pend_q  <= 1'b0;
						count_q <= count_q - CW'(drop_q);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						status_q      <= res_status_q;
						found_index_q <= res_idx_q;
						found_base_q  <= res_base_q;
						removed_q     <= res_removed_q;
						entry_count_q <= CNT_W'(count_q);
						first_base_q  <= (count_q != '0) ? first_q : '0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_index_q;
	assign found_base  = found_base_q;
	assign removed     = removed_q;
	assign entry_count = entry_count_q;
	assign first_base  = first_base_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count exceeds table depth");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == S_SHIFT) || (state_q == S_PLACE) || (state_q == S_COPY)))
		else $error("table write outside shift, place or copy");

	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (opcode == OP_INSERT) && (count_q == CW'(MAX_ENTRIES)))
		|=> ((res_status_q == ST_FULL) && (state_q == S_DONE)))
		else $error("insert into full table not reported full");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> (($past(state_q) == S_PLACE) || ($past(state_q) == S_COPY) ||
			($past(state_q) == S_IDLE)))
		else $error("entry count changed outside place, copy or clear");

	a_retain_keeps_one: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_COPY) && pend_q && !more_q) |=> (count_q != '0))
		else $error("retain emptied the table");

endmodule

### tb/ssbt_result_checker.sv
// Result checker for the sorted segment base table: mirrors the table, predicts
// one result per accepted command beat and compares each result beat in order.
// Depends on ssbt_pkg; instantiated beside the block by the testbench top.
module ssbt_result_checker #(
	parameter int MAX_ENTRIES = ssbt_pkg::MAX_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [1:0]                  opcode,
	input  logic [ssbt_pkg::BASE_W-1:0] value,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [1:0]                  status,
	input  logic [ssbt_pkg::IDX_W-1:0]  found_index,
	input  logic [ssbt_pkg::BASE_W-1:0] found_base,
	input  logic [ssbt_pkg::IDX_W-1:0]  removed,
	input  logic [ssbt_pkg::CNT_W-1:0]  entry_count,
	input  logic [ssbt_pkg::BASE_W-1:0] first_base,
	output int                          errors,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ssbt_pkg::*;

	localparam int REPORT_MAX = 120;

	typedef struct packed {
		logic [1:0]        status;
		logic [IDX_W-1:0]  found_index;
		logic [BASE_W-1:0] found_base;
		logic [IDX_W-1:0]  removed;
		logic [CNT_W-1:0]  entry_count;
		logic [BASE_W-1:0] first_base;
	} seg_result_t;

	logic [BASE_W-1:0] mirror_base [MAX_ENTRIES];
	int                mirror_count;
	seg_result_t       due_results [$];
	int                fail_cnt;

	assign errors = fail_cnt;

	// Apply one command to the mirrored table and return the result it yields.
	function automatic seg_result_t run_command(logic [1:0] op, logic [BASE_W-1:0] v);
		seg_result_t r;
		int          pos;
		int          drop;
		int          idx;
		bit          hit;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_CLEAR: begin
				mirror_count = 0;
			end
			OP_INSERT: begin
				if (mirror_count >= MAX_ENTRIES) begin
					r.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < mirror_count && mirror_base[pos] < v)
						pos++;
					if (!(pos < mirror_count && mirror_base[pos] == v)) begin
						for (int j = mirror_count; j > pos; j--)
							mirror_base[j] = mirror_base[j-1];
						mirror_base[pos] = v;
						mirror_count++;
					end
				end
			end
			OP_RETAIN: begin
				drop = 0;
				while (drop + 1 < mirror_count && mirror_base[drop+1] <= v)
					drop++;
				if (drop > 0) begin
					for (int j = 0; j + drop < mirror_count; j++)
						mirror_base[j] = mirror_base[j+drop];
					mirror_count -= drop;
				end
				r.removed = drop[IDX_W-1:0];
			end
			default: begin
				hit = 1'b0;
				idx = mirror_count;
				while (idx > 0 && !hit) begin
					idx--;
					if (mirror_base[idx] <= v)
						hit = 1'b1;
				end
				if (hit) begin
					r.found_index = idx[IDX_W-1:0];
					r.found_base  = mirror_base[idx];
				end else begin
					r.status = ST_NOT_FOUND;
				end
			end
		endcase
		r.entry_count = mirror_count[CNT_W-1:0];
		r.first_base  = (mirror_count > 0) ? mirror_base[0] : '0;
		return r;
	endfunction

	task automatic check_field(string name, logic [BASE_W-1:0] exp_v, logic [BASE_W-1:0] got_v);
		if (exp_v !== got_v) begin
			fail_cnt++;
			if (fail_cnt <= REPORT_MAX)
				$display("%0t: mismatch on %s, expected %0h, got %0h", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		seg_result_t want;
		if (!arst_n) begin
			mirror_count = 0;
			due_results.delete();
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				due_results.push_back(run_command(opcode, value));
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_MAX)
						$display("%0t: result beat with nothing expected, expected none, got %0h",
							$time, {status, found_index, found_base, removed, entry_count, first_base});
				end else begin
					want = due_results.pop_front();
					check_field("status", BASE_W'(want.status), BASE_W'(status));
					check_field("found_index", BASE_W'(want.found_index), BASE_W'(found_index));
					check_field("found_base", want.found_base, found_base);
					check_field("removed", BASE_W'(want.removed), BASE_W'(removed));
					check_field("entry_count", BASE_W'(want.entry_count), BASE_W'(entry_count));
					check_field("first_base", want.first_base, first_base);
				end
			end
			pending <= due_results.size();
		end
	end

	initial fail_cnt = 0;

endmodule

### tb/sorted_segment_base_table_top_tb.sv
// Testbench top for the sorted segment base table: clock, reset, command
// stimulus, output stall pattern and verdict. Depends on ssbt_pkg, the block
// and ssbt_result_checker, which predicts and compares every result beat.
module sorted_segment_base_table_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ssbt_pkg::*;

	// The cycle limit leaves several times the slowest run with every stall phase included.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RAND_ITEMS  = 1400;
	localparam int DRAIN_WAIT  = 2 * MAX_ENTRIES_DEF + 8;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        opcode;
	logic [BASE_W-1:0] value;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [IDX_W-1:0]  found_index;
	logic [BASE_W-1:0] found_base;
	logic [IDX_W-1:0]  removed;
	logic [CNT_W-1:0]  entry_count;
	logic [BASE_W-1:0] first_base;
	int                errors;
	int                pending;

	// Stimulus knobs and bookkeeping.
	int                idle_pct;
	int                stall_pct;
	int                sent;
	int                cycles;
	bit                drv_hi;
	logic [BASE_W-1:0] recent [64];
	int                recent_wr;

	sorted_segment_base_table_top u_dut (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .value,
		.out_valid, .out_stall, .status, .found_index, .found_base,
		.removed, .entry_count, .first_base
	);

	ssbt_result_checker u_checker (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .value,
		.out_valid, .out_stall, .status, .found_index, .found_base,
		.removed, .entry_count, .first_base, .errors, .pending
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Stall the result channel at the rate of the current phase.
	always @(posedge clk) begin
		out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
	end

	// Pick a value that lands on, next to, or far from bases seen so far, so
	// that duplicates, exact hits and near misses all come up often.
	function automatic logic [BASE_W-1:0] pick_value();
		logic [BASE_W-1:0] v;
		case ($urandom_range(9))
			0, 1, 2: v = {$urandom, $urandom};
			3, 4, 5: v = recent[$urandom_range(63)];
			6:       v = recent[$urandom_range(63)] + 1'b1;
			7:       v = recent[$urandom_range(63)] - 1'b1;
			8:       v = BASE_W'($urandom_range(300));
			default: v = $urandom_range(1) ? {BASE_W{1'b1}} : '0;
		endcase
		return v;
	endfunction

	// Opcode mix for ordinary traffic: mostly inserts and lookups.
	function automatic logic [1:0] pick_op();
		int w;
		w = $urandom_range(99);
		if (w < 45)
			return OP_INSERT;
		else if (w < 75)
			return OP_LOOKUP;
		else if (w < 96)
			return OP_RETAIN;
		return OP_CLEAR;
	endfunction

	// Present one command beat and hold it until accepted, then maybe idle.
	task automatic send_cmd(input logic [1:0] op, input logic [BASE_W-1:0] v);
		in_valid <= 1'b1;
		opcode   <= op;
		value    <= v;
		drv_hi    = 1'b1;
		recent[recent_wr] = v;
		recent_wr = (recent_wr + 1) % 64;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			// Drop valid and scramble the idle payload.
			in_valid <= 1'b0;
			opcode   <= 2'($urandom);
			value    <= {$urandom, $urandom};
			drv_hi    = 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Hold off the sender until every expected result has come back.
	task automatic wait_drained();
		if (drv_hi) begin
			in_valid <= 1'b0;
			drv_hi    = 1'b0;
		end
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// One burst of traffic: a fill past capacity, a noise burst, or a
	// mixed run of commands on a table that is often started fresh.
	task automatic run_burst();
		int kind;
		kind = $urandom_range(19);
		if (kind < 2) begin
			send_cmd(OP_CLEAR, pick_value());
			repeat (MAX_ENTRIES_DEF + $urandom_range(8))
				send_cmd(OP_INSERT, {$urandom, $urandom});
			send_cmd(OP_INSERT, recent[$urandom_range(63)]);
			repeat ($urandom_range(3, 8))
				send_cmd(pick_op(), pick_value());
		end else if (kind < 4) begin
			repeat ($urandom_range(2, 6))
				send_cmd(2'($urandom_range(3)), {$urandom, $urandom});
		end else begin
			if ($urandom_range(1))
				send_cmd(OP_CLEAR, pick_value());
			repeat ($urandom_range(10, 60))
				send_cmd(pick_op(), pick_value());
		end
	endtask

	initial begin
		int target;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		opcode    <= OP_CLEAR;
		value     <= '0;
		out_stall <= 1'b0;
		idle_pct   = 0;
		stall_pct  = 0;
		sent       = 0;
		cycles     = 0;
		drv_hi     = 1'b0;
		recent_wr  = 0;
		for (int i = 0; i < 64; i++)
			recent[i] = {$urandom, $urandom};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, one-entry retain, duplicates, both extremes,
		// lookups below, at and above bases, retain that stops at the last.
		send_cmd(OP_LOOKUP, 64'd5);
		send_cmd(OP_RETAIN, {BASE_W{1'b1}});
		send_cmd(OP_INSERT, {BASE_W{1'b1}});
		send_cmd(OP_RETAIN, {BASE_W{1'b1}});
		send_cmd(OP_INSERT, 64'd100);
		send_cmd(OP_INSERT, 64'd100);
		send_cmd(OP_LOOKUP, 64'd99);
		send_cmd(OP_LOOKUP, 64'd100);
		send_cmd(OP_LOOKUP, {BASE_W{1'b1}});
		send_cmd(OP_INSERT, 64'd0);
		send_cmd(OP_LOOKUP, 64'd0);
		send_cmd(OP_INSERT, 64'h8000_0000_0000_0000);
		send_cmd(OP_INSERT, 64'h5555_5555_5555_5555);
		send_cmd(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
		send_cmd(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF);
		send_cmd(OP_RETAIN, 64'd100);
		send_cmd(OP_RETAIN, {BASE_W{1'b1}});
		send_cmd(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE);
		send_cmd(OP_CLEAR, 64'd0);
		send_cmd(OP_LOOKUP, {BASE_W{1'b1}});
		send_cmd(OP_INSERT, 64'd7);
		send_cmd(OP_LOOKUP, 64'd6);
		wait_drained();

		// Random traffic in four phases of input idling and output stalling, draining between them.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1) ? 53 : (ph == 3) ? 34 : 0;
			stall_pct = (ph == 2) ? 53 : (ph == 3) ? 34 : 0;
			target    = sent + RAND_ITEMS / 4;
			while (sent < target)
				run_burst();
			wait_drained();
		end

		// Let any stray result beat show up before the verdict.
		stall_pct = 0;
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
